// ===== src/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

   // Mode bit of an input word.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int          VCOUNT_BITS  = 7;
   localparam logic [6:0]  VCOUNT_RESET = 7'd3;

   // What one walk slot does once its store read returns.
   typedef enum logic [1:0] {
      SLOT_FIRST = 2'd0,  // vertex zero: kept for the closing edge, no edge yet
      SLOT_EDGE  = 2'd1,  // edge from the previous vertex to the one just read
      SLOT_CLOSE = 2'd2,  // edge from the previous vertex back to vertex zero
      SLOT_NULL  = 2'd3   // no edge at all, only carries the end marker
   } pip_slot_type;

   typedef struct packed {
      logic         vld;
      pip_slot_type kind;
      logic         last;
   } pip_cmd_type;

   typedef struct packed {
      logic done;
   } pip_status_type;

endpackage

// ===== src/pip_ctrl.sv =====
`timescale 1ns / 1ps

module pip_ctrl import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              req_mode,
   input  logic                              csr_write_en,
   input  logic [VCOUNT_BITS-1:0]            csr_write_data,
   input  pip_status_type                    status,
   output pip_cmd_type                       cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
   output logic                              busy
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int KW = (CW > VCOUNT_BITS) ? CW : VCOUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   logic                     busy_ff;
   pip_cmd_type              cmd_ff;
   logic [AW-1:0]            rd_addr_ff;
   logic [CW-1:0]            cnt_ff;
   logic [CW-1:0]            n_ff;
   logic [VCOUNT_BITS-1:0]   vcount_ff;
   logic [CW-1:0]            n_in;

   // A count above the store depth saturates to it.
   always_comb begin
      if (KW'(vcount_ff) > KW'(MAX_VERTICES)) begin
         n_in = CW'(MAX_VERTICES);
      end else begin
         n_in = CW'(vcount_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         busy_ff    <= 1'b0;
         cmd_ff     <= '0;
         rd_addr_ff <= '0;
         cnt_ff     <= '0;
         n_ff       <= '0;
         vcount_ff  <= VCOUNT_RESET;
      end else begin
         if (csr_write_en) begin
            vcount_ff <= csr_write_data;
         end
         cmd_ff.vld  <= 1'b0;
         cmd_ff.last <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == MODE_QUERY) begin
                  busy_ff <= 1'b1;
                  n_ff    <= n_in;
                  if (n_in == '0) begin
                     cmd_ff.vld  <= 1'b1;
                     cmd_ff.kind <= SLOT_NULL;
                     cmd_ff.last <= 1'b1;
                     state_ff    <= ST_DRAIN;
                  end else begin
                     cmd_ff.vld  <= 1'b1;
                     cmd_ff.kind <= SLOT_FIRST;
                     rd_addr_ff  <= '0;
                     cnt_ff      <= CW'(1);
                     state_ff    <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               cmd_ff.vld <= 1'b1;
               if (cnt_ff == n_ff) begin
                  cmd_ff.kind <= SLOT_CLOSE;
                  cmd_ff.last <= 1'b1;
                  state_ff    <= ST_DRAIN;
               end else begin
                  cmd_ff.kind <= SLOT_EDGE;
                  rd_addr_ff  <= cnt_ff[AW-1:0];
                  cnt_ff      <= cnt_ff + CW'(1);
               end
            end
            ST_DRAIN: begin
               if (status.done) begin
                  busy_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign cmd     = cmd_ff;
   assign rd_addr = rd_addr_ff;
   assign busy    = busy_ff;

endmodule

// ===== src/pip_datapath.sv =====
`timescale 1ns / 1ps

module pip_datapath import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              req_mode,
   input  logic [5:0]                        req_vertex_index,
   input  logic signed [15:0]                req_vertex_x,
   input  logic signed [15:0]                req_vertex_y,
   input  logic signed [15:0]                req_point_x,
   input  logic signed [15:0]                req_point_y,
   input  pip_cmd_type                       cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
   output pip_status_type                    status,
   output logic                              rsp_strobe,
   output logic                              rsp_inside_res,
   output logic                              rsp_on_boundary
);

   localparam int CB  = COORD_BITS;
   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int DW  = CB + 1;
   localparam int PW  = 2 * DW;
   localparam int RW  = PW + 1;
   localparam int IXW = ($clog2(MAX_VERTICES + 1) > 7) ? $clog2(MAX_VERTICES + 1) : 7;

   // Vertex store, x in the upper half of each entry.
   logic [2*CB-1:0] mem [MAX_VERTICES];

   logic signed [CB-1:0] vx_in, vy_in, qx_in, qy_in;
   logic signed [CB-1:0] q_x_ff, q_y_ff;

   logic [2*CB-1:0]      rd_data_ff;
   logic                 slot_vld_ff;
   pip_slot_type         slot_kind_ff;
   logic                 slot_last_ff;
   logic signed [CB-1:0] rd_x, rd_y;
   logic signed [CB-1:0] v0_x_ff, v0_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CB-1:0] b_x_in, b_y_in;

   logic signed [CB-1:0] e_ax_ff, e_ay_ff, e_bx_ff, e_by_ff;
   logic                 e_vld_ff, e_null_ff, e_last_ff;

   logic signed [DW-1:0] dxe, dye, qxa, qya;
   logic signed [PW-1:0] p1_in, p2_in;
   logic signed [CB-1:0] lox, hix, loy, hiy;
   logic                 bbox_in, ycross_in;

   logic signed [PW-1:0] m_p1_ff, m_p2_ff;
   logic                 m_bbox_ff, m_ycross_ff, m_dyneg_ff;
   logic                 m_vld_ff, m_last_ff;

   logic signed [RW-1:0] cr;
   logic                 cr_zero, cr_pos, cr_neg, w_pos, w_neg;
   logic                 bnd_ff, right_ff, left_ff;
   logic                 bnd_in, right_in, left_in;

   logic                 rsp_strobe_ff, rsp_inside_ff, rsp_bnd_ff;

   // A coordinate is the low COORD_BITS bits of its field, read as signed.
   assign vx_in = CB'($unsigned(req_vertex_x));
   assign vy_in = CB'($unsigned(req_vertex_y));
   assign qx_in = CB'($unsigned(req_point_x));
   assign qy_in = CB'($unsigned(req_point_y));

   // Store write on a load word, registered read while walking.
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_LOAD &&
          IXW'(req_vertex_index) < IXW'(MAX_VERTICES)) begin
         mem[AW'(req_vertex_index)] <= {vx_in, vy_in};
      end
      if (cmd.vld) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_x = rd_data_ff[2*CB-1:CB];
   assign rd_y = rd_data_ff[CB-1:0];

   always_comb begin
      if (slot_kind_ff == SLOT_CLOSE) begin
         b_x_in = v0_x_ff;
         b_y_in = v0_y_ff;
      end else begin
         b_x_in = rd_x;
         b_y_in = rd_y;
      end
   end

   // Edge geometry. The crossing side w equals the cross product, negated
   // when the edge runs downward, so two multipliers serve both tests.
   always_comb begin
      dxe = DW'(e_bx_ff) - DW'(e_ax_ff);
      dye = DW'(e_by_ff) - DW'(e_ay_ff);
      qxa = DW'(q_x_ff) - DW'(e_ax_ff);
      qya = DW'(q_y_ff) - DW'(e_ay_ff);
      p1_in = PW'(dxe) * PW'(qya);
      p2_in = PW'(dye) * PW'(qxa);
      lox = (e_ax_ff < e_bx_ff) ? e_ax_ff : e_bx_ff;
      hix = (e_ax_ff < e_bx_ff) ? e_bx_ff : e_ax_ff;
      loy = (e_ay_ff < e_by_ff) ? e_ay_ff : e_by_ff;
      hiy = (e_ay_ff < e_by_ff) ? e_by_ff : e_ay_ff;
      bbox_in = (q_x_ff >= lox) && (q_x_ff <= hix) &&
                (q_y_ff >= loy) && (q_y_ff <= hiy);
      // The ray meets the edge when the point's y lies above the lower end
      // and at or below the upper end; a flat edge never satisfies this.
      ycross_in = (q_y_ff > loy) && (q_y_ff <= hiy);
   end

   always_comb begin
      cr       = RW'(m_p1_ff) - RW'(m_p2_ff);
      cr_zero  = (cr == '0);
      cr_neg   = cr[RW-1];
      cr_pos   = !cr_neg && !cr_zero;
      w_pos    = m_dyneg_ff ? cr_neg : cr_pos;
      w_neg    = m_dyneg_ff ? cr_pos : cr_neg;
      bnd_in   = bnd_ff | (cr_zero & m_bbox_ff);
      right_in = right_ff ^ (m_ycross_ff & w_pos);
      left_in  = left_ff ^ (m_ycross_ff & w_neg);
   end

   // Valid bits of the walk pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff   <= 1'b0;
         e_vld_ff      <= 1'b0;
         m_vld_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         slot_vld_ff   <= cmd.vld;
         e_vld_ff      <= slot_vld_ff && slot_kind_ff != SLOT_FIRST;
         m_vld_ff      <= e_vld_ff;
         rsp_strobe_ff <= m_vld_ff && m_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_QUERY) begin
         q_x_ff <= qx_in;
         q_y_ff <= qy_in;
      end

      slot_kind_ff <= cmd.kind;
      slot_last_ff <= cmd.last;

      if (slot_vld_ff) begin
         unique case (slot_kind_ff)
            SLOT_FIRST: begin
               v0_x_ff   <= rd_x;
               v0_y_ff   <= rd_y;
               prev_x_ff <= rd_x;
               prev_y_ff <= rd_y;
            end
            SLOT_EDGE: begin
               prev_x_ff <= rd_x;
               prev_y_ff <= rd_y;
            end
            SLOT_CLOSE, SLOT_NULL: begin
            end
         endcase
      end
      e_ax_ff   <= prev_x_ff;
      e_ay_ff   <= prev_y_ff;
      e_bx_ff   <= b_x_in;
      e_by_ff   <= b_y_in;
      e_null_ff <= (slot_kind_ff == SLOT_NULL);
      e_last_ff <= slot_last_ff;

      m_p1_ff     <= p1_in;
      m_p2_ff     <= p2_in;
      m_bbox_ff   <= bbox_in && !e_null_ff;
      m_ycross_ff <= ycross_in && !e_null_ff;
      m_dyneg_ff  <= dye[DW-1];
      m_last_ff   <= e_last_ff;

      if (accept && req_mode == MODE_QUERY) begin
         bnd_ff   <= 1'b0;
         right_ff <= 1'b0;
         left_ff  <= 1'b0;
      end else if (m_vld_ff) begin
         bnd_ff   <= bnd_in;
         right_ff <= right_in;
         left_ff  <= left_in;
      end

      if (m_vld_ff && m_last_ff) begin
         rsp_inside_ff <= bnd_in | (right_in & left_in);
         rsp_bnd_ff    <= bnd_in;
      end
   end

   assign status.done     = rsp_strobe_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_on_boundary = rsp_bnd_ff;

endmodule

// ===== src/point_in_polygon_test.sv =====
`timescale 1ns / 1ps

// Point-in-polygon test by ray crossing count over a stored polygon.
// Input words are offered on start with the req_ ports; a word is taken at a
// clock edge where start is high and busy is low. A load word (req_mode 0)
// writes one vertex into the store and gives no result; busy stays low, so
// the next word may follow in the next cycle. A query word (req_mode 1) walks
// every edge of the polygon, the last one closing back to vertex zero.
// The walk reads n vertices, where n is the vertex count (saturated to
// MAX_VERTICES), one vertex a cycle from the single read port of the store.
// Busy drops the cycle after the result strobe, so the next word can be taken
// once busy is low. A count of zero walks no edge but still gives a strobe.
// The result is on rsp_inside_res and rsp_on_boundary in the cycle in which
// rsp_strobe is high; the receiver cannot hold it off. The vertex count is
// written through csr_write_en and csr_write_data; the user must do so only
// while the block is idle, which the block leaves unchecked. Reset sets the
// count to three and ends any walk; the vertex store is not cleared and must
// be loaded before it is queried.
module point_in_polygon_test import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_mode,
   input  logic [5:0]             req_vertex_index,
   input  logic signed [15:0]     req_vertex_x,
   input  logic signed [15:0]     req_vertex_y,
   input  logic signed [15:0]     req_point_x,
   input  logic signed [15:0]     req_point_y,
   output logic                   rsp_strobe,
   output logic                   rsp_inside_res,
   output logic                   rsp_on_boundary,
   input  logic                   csr_write_en,
   input  logic [VCOUNT_BITS-1:0] csr_write_data
);

   localparam int AW = $clog2(MAX_VERTICES);

   logic           accept;
   logic           busy_int;
   pip_cmd_type    cmd;
   pip_status_type status;
   logic [AW-1:0]  rd_addr;

   assign accept = start && !busy_int;
   assign busy   = busy_int;

   pip_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_mode       (req_mode),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .status         (status),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .busy           (busy_int)
   );

   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_mode         (req_mode),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_on_boundary  (rsp_on_boundary)
   );

endmodule
